>>> src/lpf_pkg.sv
`default_nettype none
package lpf_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int ADDR_W       = $clog2(MAX_POINTS);
    localparam int CNT_W        = $clog2(MAX_POINTS + 1);
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int CW           = 36;
    localparam int ZW           = 34;
    localparam int CFG_W        = 31;
    localparam int CFG_IDX_W    = 3;
    localparam int NUM_CFG      = 6;

    localparam int PI_Q13       = 25736;
    localparam int HALF_PI_Q13  = 12868;
    localparam logic signed [ZW-1:0] Z_PREROT = 34'sd1686629713;
    localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_TOL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_LIM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_LIM   = 3'd5;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [ZW-1:0] ATAN_HEAD [10] = '{
        34'd843314856, 34'd497837829, 34'd263043836, 34'd133525158, 34'd67021686,
        34'd33543515,  34'd16775850,  34'd8388437,   34'd4194282,   34'd2097149
    };

    typedef enum logic [4:0] {
        S_IDLE,
        S_YAW_MUL,
        S_YAW_START,
        S_YAW_WAIT,
        S_RD,
        S_DIFF,
        S_ABS,
        S_SQX,
        S_SQY,
        S_SQRT,
        S_DIST,
        S_CHK,
        S_ANG_START,
        S_ANG_WAIT,
        S_EVAL,
        S_NEXT,
        S_OUT_MUL,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        PASS_AHEAD,
        PASS_ANY,
        PASS_FINAL
    } pass_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic [ZW-1:0] r;
        if (32'(i) < 10)
            r = ATAN_HEAD[i];
        else if (32'(i) > 30)
            r = '0;
        else
            r = (ZW'(1) << (ZW'(30) - ZW'(i))) - ZW'(1);
        return $signed(r);
    endfunction

endpackage
`default_nettype wire

>>> src/lpf_ram.sv
`default_nettype none
module lpf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> src/lpf_cordic.sv
`default_nettype none
module lpf_cordic (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [lpf_pkg::CW-1:0] y_in,
    input  logic signed [lpf_pkg::CW-1:0] x_in,
    output logic                          done,
    output logic signed [15:0]            angle
);
    import lpf_pkg::*;

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic                 zero_reg, zero_next;
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] zr;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        zero_next = zero_reg;
        xs        = x_reg >>> step_reg;
        ys        = y_reg >>> step_reg;
        if (start)
        begin
            step_next = '0;
            zero_next = (x_in == '0) && (y_in == '0);
            run_next  = !zero_next;
            done_next = zero_next;
            x_next    = x_in;
            y_next    = y_in;
            z_next    = '0;
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_next = y_in;
                    y_next = -x_in;
                    z_next = Z_PREROT;
                end
                else
                begin
                    x_next = -y_in;
                    y_next = x_in;
                    z_next = -Z_PREROT;
                end
            end
        end
        else if (run_reg)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_entry(step_reg);
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_entry(step_reg);
            end
            step_next = step_reg + 1'b1;
            if (32'(step_reg) == CORDIC_STEPS - 1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            zero_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
            zero_reg <= zero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign zr    = (z_reg + ZW'(65536)) >>> 17;
    assign done  = done_reg;
    assign angle = zero_reg ? 16'sd0 : zr[15:0];

endmodule
`default_nettype wire

>>> src/lookahead_path_follower_core.sv
// A load beat is absorbed on accept and leaves the block idle. A tick with N stored points
// first computes the yaw (16-step CORDIC), then scans the points: a point of the first scan that
// needs a bearing runs a 32-step square root and a 16-step CORDIC, any other point of the first
// scan and each point of the fallback scan runs only the square root; a target pass ends in the done strobe.
// One item at a time; busy is high while a tick runs; the receiver cannot stall.
// Reset clears point count, control state and loads the register defaults; memories are not cleared.
`default_nettype none
module lookahead_path_follower_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    output logic                                done,
    input  logic                                cfg_we,
    input  logic [lpf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lpf_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                req_type,
    input  logic signed [31:0]                  path_x,
    input  logic signed [31:0]                  path_y,
    input  logic                                path_start,
    input  logic signed [31:0]                  robot_x,
    input  logic signed [31:0]                  robot_y,
    input  logic signed [15:0]                  quat_w,
    input  logic signed [15:0]                  quat_x,
    input  logic signed [15:0]                  quat_y,
    input  logic signed [15:0]                  quat_z,
    output logic signed [31:0]                  linear_cmd,
    output logic signed [31:0]                  angular_cmd,
    output logic [9:0]                          target_index,
    output logic                                goal_reached
);
    import lpf_pkg::*;

    state_t state_reg, state_next;
    pass_t  pass_reg, pass_next;

    logic [CFG_W-1:0]     cfg_reg [NUM_CFG];
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ADDR_W-1:0]    idx_reg, idx_next, best_idx_reg, best_idx_next;
    logic [32:0]          best_d_reg, best_d_next;
    logic                 found_reg, found_next;
    logic signed [31:0]   rx_reg, ry_reg;
    logic signed [15:0]   qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [31:0]   p_wz_reg, p_xy_reg, p_yy_reg, p_zz_reg;
    logic signed [15:0]   yaw_reg, yaw_next;
    logic signed [32:0]   dx_reg, dy_reg;
    logic [31:0]          ax_reg, ay_reg;
    logic                 half_reg;
    logic [63:0]          n_reg, n_next, res_reg, res_next, bit_reg, bit_next;
    logic [32:0]          d_reg, d_next;
    logic signed [16:0]   err_reg, err_next;
    logic [63:0]          lin_prod_reg;
    logic [47:0]          ang_prod_reg;
    logic                 done_reg, done_next;
    logic signed [31:0]   lin_reg, lin_next, ang_reg, ang_next;
    logic [ADDR_W-1:0]    tgt_reg;
    logic                 goal_reg, goal_next;

    logic                 accept, load_we;
    logic [ADDR_W-1:0]    load_addr;
    logic [31:0]          mem_x, mem_y;
    logic                 cor_start, cor_done;
    logic signed [CW-1:0] cor_y, cor_x;
    logic signed [15:0]   cor_angle;
    logic signed [33:0]   yaw_y, yaw_x;
    logic signed [32:0]   dx_c, dy_c;
    logic [32:0]          ax_full, ay_full;
    logic [63:0]          sq_sum;
    logic signed [17:0]   diff, wrapped;
    logic [16:0]          aerr;
    logic [47:0]          lin_mag, ang_mag;
    logic [32:0]          look;
    logic                 last;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign load_we   = accept && (req_type == REQ_LOAD)
                       && (path_start || (32'(cnt_reg) < MAX_POINTS));
    assign load_addr = path_start ? '0 : cnt_reg[ADDR_W-1:0];
    assign look      = {2'b00, cfg_reg[CFG_LOOKAHEAD]};
    assign last      = (idx_reg == ADDR_W'(cnt_reg - 1'b1));
    assign aerr      = err_reg[16] ? 17'(-err_reg) : 17'(err_reg);

    lpf_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_addr),
        .wdata (path_x),
        .raddr (idx_reg),
        .rdata (mem_x)
    );

    lpf_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_addr),
        .wdata (path_y),
        .raddr (idx_reg),
        .rdata (mem_y)
    );

    assign yaw_y     = (34'(p_wz_reg) + 34'(p_xy_reg)) <<< 1;
    assign yaw_x     = ONE_Q28 - ((34'(p_yy_reg) + 34'(p_zz_reg)) <<< 1);
    assign cor_start = (state_reg == S_YAW_START) || (state_reg == S_ANG_START);
    assign cor_y     = (state_reg == S_YAW_START) ? CW'(yaw_y) : CW'(dy_reg);
    assign cor_x     = (state_reg == S_YAW_START) ? CW'(yaw_x) : CW'(dx_reg);

    lpf_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .y_in  (cor_y),
        .x_in  (cor_x),
        .done  (cor_done),
        .angle (cor_angle)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_type == REQ_TICK) && (cnt_reg != '0))
                    state_next = S_YAW_MUL;
            end
            S_YAW_MUL:   state_next = S_YAW_START;
            S_YAW_START: state_next = S_YAW_WAIT;
            S_YAW_WAIT:  if (cor_done) state_next = S_RD;
            S_RD:        state_next = S_DIFF;
            S_DIFF:      state_next = S_ABS;
            S_ABS:       state_next = S_SQX;
            S_SQX:       state_next = S_SQY;
            S_SQY:       state_next = S_SQRT;
            S_SQRT:      if (bit_reg[0]) state_next = S_DIST;
            S_DIST:      state_next = S_CHK;
            S_CHK:
            begin
                if (pass_reg == PASS_FINAL)
                    state_next = S_ANG_START;
                else if (pass_reg == PASS_AHEAD && d_reg >= look)
                    state_next = S_ANG_START;
                else
                    state_next = S_NEXT;
            end
            S_ANG_START: state_next = S_ANG_WAIT;
            S_ANG_WAIT:  if (cor_done) state_next = S_EVAL;
            S_EVAL:      state_next = (pass_reg == PASS_FINAL) ? S_OUT_MUL : S_NEXT;
            S_NEXT:      state_next = S_RD;
            S_OUT_MUL:   state_next = S_OUT;
            S_OUT:       state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next      = cnt_reg;
        pass_next     = pass_reg;
        idx_next      = idx_reg;
        best_idx_next = best_idx_reg;
        best_d_next   = best_d_reg;
        found_next    = found_reg;
        yaw_next      = yaw_reg;
        n_next        = n_reg;
        res_next      = res_reg;
        bit_next      = bit_reg;
        d_next        = d_reg;
        err_next      = err_reg;
        done_next     = 1'b0;
        lin_next      = lin_reg;
        ang_next      = ang_reg;
        goal_next     = goal_reg;
        dx_c          = 33'($signed(mem_x)) - 33'(rx_reg);
        dy_c          = 33'($signed(mem_y)) - 33'(ry_reg);
        ax_full       = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        ay_full       = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
        sq_sum        = res_reg + bit_reg;
        diff          = 18'(cor_angle) - 18'(yaw_reg);
        wrapped       = diff;
        if (wrapped > 18'sd25736)
            wrapped = wrapped - 18'(2 * PI_Q13);
        if (wrapped < -18'sd25736)
            wrapped = wrapped + 18'(2 * PI_Q13);
        lin_mag       = lin_prod_reg[63:16];
        ang_mag       = 48'(ang_prod_reg >> 13);

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_type == REQ_LOAD) && load_we)
                    cnt_next = path_start ? CNT_W'(1) : cnt_reg + 1'b1;
                pass_next     = PASS_AHEAD;
                idx_next      = '0;
                best_idx_next = '0;
                found_next    = 1'b0;
            end
            S_YAW_WAIT:
            begin
                if (cor_done)
                    yaw_next = cor_angle;
            end
            S_SQY:
            begin
                n_next   = n_reg + ay_reg * ay_reg;
                res_next = '0;
                bit_next = 64'd1 << 62;
            end
            S_SQRT:
            begin
                if (n_reg >= sq_sum)
                begin
                    n_next   = n_reg - sq_sum;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            S_DIST:
            begin
                d_next = half_reg ? {res_reg[31:0], 1'b0} : {1'b0, res_reg[31:0]};
            end
            S_CHK:
            begin
                if (pass_reg == PASS_ANY && d_reg >= look
                    && (!found_reg || d_reg < best_d_reg))
                begin
                    best_d_next   = d_reg;
                    best_idx_next = idx_reg;
                    found_next    = 1'b1;
                end
            end
            S_ANG_WAIT:
            begin
                if (cor_done)
                    err_next = wrapped[16:0];
            end
            S_EVAL:
            begin
                if (pass_reg == PASS_AHEAD && 32'(aerr) < HALF_PI_Q13
                    && (!found_reg || d_reg < best_d_reg))
                begin
                    best_d_next   = d_reg;
                    best_idx_next = idx_reg;
                    found_next    = 1'b1;
                end
            end
            S_NEXT:
            begin
                if (!last)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else if (pass_reg == PASS_AHEAD && !found_reg)
                begin
                    pass_next = PASS_ANY;
                    idx_next  = '0;
                end
                else
                begin
                    pass_next = PASS_FINAL;
                    idx_next  = best_idx_reg;
                end
            end
            S_OUT:
            begin
                lin_next = (lin_mag > 48'(cfg_reg[CFG_LIN_LIM]))
                           ? 32'(cfg_reg[CFG_LIN_LIM]) : lin_mag[31:0];
                if (32'(aerr) > HALF_PI_Q13)
                    lin_next = -lin_next;
                ang_next = (ang_mag > 48'(cfg_reg[CFG_ANG_LIM]))
                           ? 32'(cfg_reg[CFG_ANG_LIM]) : ang_mag[31:0];
                if (err_reg < 0)
                    ang_next = -ang_next;
                goal_next = d_reg < {2'b00, cfg_reg[CFG_GOAL_TOL]};
                if (goal_next)
                begin
                    lin_next = '0;
                    ang_next = '0;
                end
                done_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pass_reg     <= PASS_AHEAD;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            best_idx_reg <= '0;
            found_reg    <= 1'b0;
            done_reg     <= 1'b0;
            cfg_reg[CFG_LOOKAHEAD] <= 31'd65536;
            cfg_reg[CFG_GOAL_TOL]  <= 31'd32768;
            cfg_reg[CFG_LIN_GAIN]  <= 31'd32768;
            cfg_reg[CFG_ANG_GAIN]  <= 31'd13107;
            cfg_reg[CFG_LIN_LIM]   <= 31'd32768;
            cfg_reg[CFG_ANG_LIM]   <= 31'd32768;
        end
        else
        begin
            state_reg    <= state_next;
            pass_reg     <= pass_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            best_idx_reg <= best_idx_next;
            found_reg    <= found_next;
            done_reg     <= done_next;
            if (cfg_we && (32'(cfg_index) < NUM_CFG))
                cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rx_reg <= robot_x;
            ry_reg <= robot_y;
            qw_reg <= quat_w;
            qx_reg <= quat_x;
            qy_reg <= quat_y;
            qz_reg <= quat_z;
        end
        if (state_reg == S_YAW_MUL)
        begin
            p_wz_reg <= qw_reg * qz_reg;
            p_xy_reg <= qx_reg * qy_reg;
            p_yy_reg <= qy_reg * qy_reg;
            p_zz_reg <= qz_reg * qz_reg;
        end
        if (state_reg == S_DIFF)
        begin
            dx_reg <= dx_c;
            dy_reg <= dy_c;
        end
        if (state_reg == S_ABS)
        begin
            half_reg <= ax_full[32] || ax_full[31] || ay_full[32] || ay_full[31];
            if (ax_full[32] || ax_full[31] || ay_full[32] || ay_full[31])
            begin
                ax_reg <= ax_full[32:1];
                ay_reg <= ay_full[32:1];
            end
            else
            begin
                ax_reg <= ax_full[31:0];
                ay_reg <= ay_full[31:0];
            end
        end
        if (state_reg == S_SQX)
            n_reg <= ax_reg * ax_reg;
        else
            n_reg <= n_next;
        if (state_reg == S_OUT_MUL)
        begin
            lin_prod_reg <= 64'(cfg_reg[CFG_LIN_GAIN]) * 64'(d_reg);
            ang_prod_reg <= 48'(aerr) * 48'(cfg_reg[CFG_ANG_GAIN]);
        end
        if (state_reg == S_OUT)
            tgt_reg <= idx_reg;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        d_reg      <= d_next;
        err_reg    <= err_next;
        yaw_reg    <= yaw_next;
        best_d_reg <= best_d_next;
        lin_reg    <= lin_next;
        ang_reg    <= ang_next;
        goal_reg   <= goal_next;
    end

    assign done         = done_reg;
    assign linear_cmd   = lin_reg;
    assign angular_cmd  = ang_reg;
    assign target_index = 10'(tgt_reg);
    assign goal_reached = goal_reg;

endmodule
`default_nettype wire

>>> src/lpf_checker.sv
`default_nettype none
module lpf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        req_type,
    input logic [31:0] linear_cmd,
    input logic [31:0] angular_cmd,
    input logic        goal_reached
);
    import lpf_pkg::*;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a running tick");

    a_goal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && goal_reached) |-> (linear_cmd == '0 && angular_cmd == '0))
        else $error("nonzero command at goal");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_LOAD) |=> (!busy && !done))
        else $error("load beat caused activity");

endmodule

bind lookahead_path_follower_core lpf_checker u_lpf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .req_type     (req_type),
    .linear_cmd   (linear_cmd),
    .angular_cmd  (angular_cmd),
    .goal_reached (goal_reached)
);
`default_nettype wire
